FILE: rtl/lzwd_pkg.sv
// Types and constants shared by the LZ window decompressor modules.
// No dependencies; every other file of the block but lzwd_history imports this package.
package lzwd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       block_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_TOKEN,
    PH_PARAM1,
    PH_PARAM2,
    PH_LITERAL
  } phase_t;

  // Token kinds, taken from the top two bits of a token byte.
  localparam logic [1:0] KIND_LITERAL = 2'b00;
  localparam logic [1:0] KIND_NEAR    = 2'b01;
  localparam logic [1:0] KIND_SHORT   = 2'b10;
  localparam logic [1:0] KIND_FAR     = 2'b11;

  localparam int DIST_W = 13;
  localparam int LEN_W  = 6;
  localparam int LIT_W  = 7;

  localparam logic [LEN_W-1:0]  LEN_BIAS_SHORT = 6'd3;
  localparam logic [LEN_W-1:0]  LEN_BIAS_FAR   = 6'd4;
  localparam logic [DIST_W-1:0] DIST_BIAS      = 13'd1;

  typedef struct packed {
    logic              start;
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  len;
  } match_cmd_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } lit_t;

endpackage

FILE: rtl/lz_window_decompressor.sv
// LZ window decompressor: one compressed byte per input transaction, one
// decompressed byte per output transaction. The byte that completes a match
// holds the input until the match (3 to 35 bytes) is copied, one byte per
// cycle while the output queue has room, through the single read port of
// the history memory, which has a registered read. After reset the history
// is swept to zero, one entry per cycle, during which no input is taken. An
// output byte waits in a two-entry queue, so stalls on the result side slow
// the copy but lose nothing.
module lz_window_decompressor import lzwd_pkg::*; #(
  parameter int WINDOW_SIZE = 8192
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  localparam int AW = $clog2(WINDOW_SIZE);

  logic          fire;
  match_cmd_t    cmd;
  lit_t          lit;
  logic          lit_phase;
  logic          clearing;
  logic          busy;
  logic [1:0]    avail;
  logic          rd_en, wr_en, push;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    rd_data, wr_data;
  out_item_t     push_item;

  assign item_ready = !clearing && !busy && (!lit_phase || (avail != 2'd0));
  assign fire       = item_valid && item_ready;

  lzwd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .cmd       (cmd),
    .lit       (lit),
    .lit_phase (lit_phase)
  );

  lzwd_history #(.WINDOW_SIZE(WINDOW_SIZE)) u_history (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .clearing (clearing)
  );

  lzwd_copy #(.WINDOW_SIZE(WINDOW_SIZE)) u_copy (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .lit       (lit),
    .avail     (avail),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_item (push_item),
    .busy      (busy)
  );

  lzwd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .valid     (result_valid),
    .ready     (result_ready),
    .head      (result),
    .avail     (avail)
  );

endmodule

FILE: rtl/lzwd_parser.sv
// Token parser: tracks the parse phase, holds partial tokens and decodes
// match commands and literal bytes. Depends on lzwd_pkg.
module lzwd_parser import lzwd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  in_item_t   item,
  output match_cmd_t cmd,
  output lit_t       lit,
  output logic       lit_phase
);

  phase_t           phase, phase_next;
  logic [7:0]       token, token_next;
  logic [7:0]       param, param_next;
  logic [LIT_W-1:0] lits_left, lits_next;
  logic [7:0]       b;
  logic [1:0]       kind;

  assign b    = item.in_byte;
  assign kind = token[7:6];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TOKEN;
      token     <= '0;
      param     <= '0;
      lits_left <= '0;
    end else begin
      phase     <= phase_next;
      token     <= token_next;
      param     <= param_next;
      lits_left <= lits_next;
    end
  end

  always_comb begin
    phase_next = phase;
    token_next = token;
    param_next = param;
    lits_next  = lits_left;
    if (fire) begin
      unique case (phase)
        PH_TOKEN: begin
          token_next = b;
          if (b[7:6] == KIND_LITERAL) begin
            lits_next  = {1'b0, b[5:0]} + LIT_W'(1);
            phase_next = PH_LITERAL;
          end else begin
            phase_next = PH_PARAM1;
          end
        end
        PH_PARAM1: begin
          unique case (kind)
            KIND_NEAR: begin
              lits_next  = '0;
              phase_next = PH_TOKEN;
            end
            KIND_SHORT: begin
              lits_next  = LIT_W'(b[3:0]);
              phase_next = (b[3:0] != 4'd0) ? PH_LITERAL : PH_TOKEN;
            end
            KIND_FAR: begin
              param_next = b;
              phase_next = PH_PARAM2;
            end
            default: begin
              phase_next = PH_TOKEN;
            end
          endcase
        end
        PH_PARAM2: begin
          lits_next  = LIT_W'(b[3:0]);
          phase_next = (b[3:0] != 4'd0) ? PH_LITERAL : PH_TOKEN;
        end
        PH_LITERAL: begin
          lits_next = lits_left - LIT_W'(1);
          if (lits_left == LIT_W'(1)) begin
            phase_next = PH_TOKEN;
          end
        end
        default: begin
          phase_next = PH_TOKEN;
        end
      endcase
      // The end of a block drops any partial token and pending literals.
      if (item.block_end) begin
        phase_next = PH_TOKEN;
        lits_next  = '0;
      end
    end
  end

  always_comb begin
    cmd       = '0;
    lit       = '0;
    lit_phase = (phase == PH_LITERAL);
    if (fire) begin
      unique case (phase)
        PH_PARAM1: begin
          unique case (kind)
            KIND_NEAR: begin
              cmd.start    = 1'b1;
              cmd.distance = DIST_W'({token[5:0], b[7:5]}) + DIST_BIAS;
              cmd.len      = LEN_W'(b[4:0]) + LEN_BIAS_SHORT;
            end
            KIND_SHORT: begin
              cmd.start    = 1'b1;
              cmd.distance = DIST_W'({token[5:0], b[7]}) + DIST_BIAS;
              cmd.len      = LEN_W'(b[6:4]) + LEN_BIAS_SHORT;
            end
            default: begin
              cmd = '0;
            end
          endcase
        end
        PH_PARAM2: begin
          cmd.start    = 1'b1;
          cmd.distance = {token[5:0], param[7:1]};
          cmd.len      = LEN_W'({param[0], b[7:4]}) + LEN_BIAS_FAR;
        end
        PH_LITERAL: begin
          lit.valid = 1'b1;
          lit.data  = b;
        end
        default: begin
          cmd = '0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/lzwd_history.sv
// History window: a single-port-write, single-port-read memory of past
// output bytes with a registered read, cleared by a sweep after reset.
module lzwd_history #(
  parameter  int WINDOW_SIZE = 8192,
  localparam int AW          = $clog2(WINDOW_SIZE)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output logic          clearing
);

  logic [7:0]    mem [WINDOW_SIZE];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(WINDOW_SIZE - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/lzwd_copy.sv
// Copy engine: owns the write position, issues one history read per cycle
// for a match while the output queue has room, writes every output byte back
// and forwards a byte read in the cycle it is written. Depends on lzwd_pkg.
module lzwd_copy import lzwd_pkg::*; #(
  parameter  int WINDOW_SIZE = 8192,
  localparam int AW          = $clog2(WINDOW_SIZE)
) (
  input  logic          clk,
  input  logic          rst,
  input  match_cmd_t    cmd,
  input  lit_t          lit,
  input  logic [1:0]    avail,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          push,
  output out_item_t     push_item,
  output logic          busy
);

  logic [AW-1:0]    wp, wp_inc;
  logic [AW-1:0]    src, src_inc, src0;
  logic [AW:0]      src_wide;
  logic [LEN_W-1:0] left;
  logic             pend, pend_last, pend_fwd;
  logic [7:0]       last_wdata, fetched;
  logic             issue;

  // Source of the first copied byte: write position less the distance,
  // wrapped into the window. A distance of zero lands on the write position.
  assign src_wide = (AW+1)'(WINDOW_SIZE) + {1'b0, wp} - (AW+1)'(cmd.distance);
  assign src0     = (src_wide >= (AW+1)'(WINDOW_SIZE)) ?
                    AW'(src_wide - (AW+1)'(WINDOW_SIZE)) : AW'(src_wide);
  assign src_inc  = (src == AW'(WINDOW_SIZE - 1)) ? '0 : src + AW'(1);
  assign wp_inc   = (wp == AW'(WINDOW_SIZE - 1)) ? '0 : wp + AW'(1);

  // A read is only issued when its byte is sure to find room in the output
  // queue in the next cycle, when the byte is pushed.
  assign issue   = (left != '0) && (avail > {1'b0, pend});
  assign rd_en   = issue;
  assign rd_addr = src;
  assign fetched = pend_fwd ? last_wdata : rd_data;
  assign busy    = (left != '0) || pend;

  always_comb begin
    wr_en                 = lit.valid || pend;
    wr_addr               = wp;
    wr_data               = lit.valid ? lit.data : fetched;
    push                  = wr_en;
    push_item.out_byte    = wr_data;
    push_item.last_of_run = lit.valid ? 1'b1 : pend_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      pend <= 1'b0;
      wp   <= '0;
    end else begin
      if (cmd.start) begin
        left <= cmd.len;
      end else if (issue) begin
        left <= left - LEN_W'(1);
      end
      pend <= issue;
      if (wr_en) begin
        wp <= wp_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      src <= src0;
    end else if (issue) begin
      src <= src_inc;
    end
    if (issue) begin
      pend_last <= (left == LEN_W'(1));
      // The slot being written this cycle is read with its old contents,
      // so the new byte is taken from the forwarding register instead.
      pend_fwd  <= pend && (src == wp);
    end
    if (wr_en) begin
      last_wdata <= wr_data;
    end
  end

endmodule

FILE: rtl/lzwd_out_fifo.sv
// Two-entry output queue that separates the copy engine from the result
// channel. Depends on lzwd_pkg.
module lzwd_out_fifo import lzwd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  out_item_t  push_item,
  output logic       valid,
  input  logic       ready,
  output out_item_t  head,
  output logic [1:0] avail
);

  out_item_t  entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign valid = (count != 2'd0);
  assign head  = entries[rd_ptr];
  assign pop   = valid && ready;
  // Free slots once this cycle's pop has gone.
  assign avail = 2'd2 - count + {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: rtl/lzwd_checker.sv
// Port-level checks for the LZ window decompressor, bound to its top level.
// Depends on lzwd_pkg and lz_window_decompressor.
module lzwd_checker import lzwd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      item_valid,
  input logic      item_ready,
  input in_item_t  item,
  input logic      result_valid,
  input logic      result_ready,
  input out_item_t result
);

  // A stalled result transaction keeps its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // The history sweep follows reset, so no input is taken straight after it.
  a_no_input_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !item_ready)
    else $error("input taken during history clear");

  // Reset empties the output queue.
  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result shown straight after reset");

endmodule

bind lz_window_decompressor lzwd_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

FILE: sim/lz_window_decompressor_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lz_window_decompressor: directed token table, then random
// token streams under random idling on both channels, checked against a behavioural decoder.
// Depends on rtl/lzwd_pkg.sv and rtl/lz_window_decompressor.sv.
module lz_window_decompressor_tb;
  import lzwd_pkg::*;

  localparam int WINDOW         = 8192;
  localparam int RANDOM_ITEMS   = 350;
  localparam int CALM_TAIL      = 60;
  localparam int SETTLE_CYCLES  = 64;
  // The input stays closed while the history sweep after reset clears all WINDOW entries.
  localparam int WATCHDOG_LIMIT = 4 * WINDOW + 1000;

  typedef struct packed {
    logic [7:0] b;
    logic       be;
    logic       typed;
    logic [5:0] n;
    logic [7:0] val;
  } dir_row_t;

  typedef struct {
    bit         typed;
    int         n;
    logic [7:0] val;
  } plan_t;

  // Rows with typed set carry n copies of val as the expected output.
  localparam dir_row_t DIRECTED [25] = '{
    '{8'hC0, 1'b0, 1'b1, 6'd0,  8'h00},  // far token
    '{8'h00, 1'b0, 1'b1, 6'd0,  8'h00},
    '{8'h00, 1'b0, 1'b1, 6'd4,  8'h00},  // distance zero into cleared history
    '{8'h02, 1'b0, 1'b1, 6'd0,  8'h00},  // three literals
    '{8'h00, 1'b0, 1'b1, 6'd1,  8'h00},
    '{8'hFF, 1'b0, 1'b1, 6'd1,  8'hFF},
    '{8'hA5, 1'b0, 1'b1, 6'd1,  8'hA5},
    '{8'h40, 1'b0, 1'b1, 6'd0,  8'h00},  // near, distance 1: overlapping repeat
    '{8'h00, 1'b0, 1'b1, 6'd3,  8'hA5},
    '{8'h80, 1'b0, 1'b1, 6'd0,  8'h00},  // short, no trailing literals
    '{8'h00, 1'b0, 1'b1, 6'd3,  8'hA5},
    '{8'h7F, 1'b0, 1'b0, 6'd0,  8'h00},  // near at its longest and farthest
    '{8'hFF, 1'b0, 1'b0, 6'd0,  8'h00},
    '{8'hBF, 1'b0, 1'b0, 6'd0,  8'h00},  // short at its longest, fifteen literals
    '{8'hFF, 1'b0, 1'b0, 6'd0,  8'h00},
    '{8'h11, 1'b1, 1'b1, 6'd1,  8'h11},  // block end drops the other literals
    '{8'hFF, 1'b0, 1'b0, 6'd0,  8'h00},  // far at its longest and farthest
    '{8'hFF, 1'b0, 1'b0, 6'd0,  8'h00},
    '{8'hF0, 1'b0, 1'b0, 6'd0,  8'h00},
    '{8'h41, 1'b1, 1'b1, 6'd0,  8'h00},  // block end on a lone token
    '{8'h3F, 1'b1, 1'b1, 6'd0,  8'h00},  // run of 64 cut short at once
    '{8'h00, 1'b0, 1'b1, 6'd0,  8'h00},
    '{8'h33, 1'b0, 1'b1, 6'd1,  8'h33},
    '{8'hC1, 1'b0, 1'b1, 6'd0,  8'h00},
    '{8'h3B, 1'b1, 1'b1, 6'd0,  8'h00}   // block end between far parameters
  };

  logic      clk          = 1'b0;
  logic      rst          = 1'b1;
  logic      item_valid   = 1'b0;
  logic      item_ready;
  in_item_t  item         = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result;

  // Decoder state kept by the testbench.
  logic [7:0]        hist [WINDOW];
  logic [DIST_W-1:0] wpos;
  phase_t            phase;
  logic [7:0]        tok_hold;
  logic [7:0]        par_hold;
  logic [LIT_W-1:0]  lits_left;

  out_item_t fresh_q[$];
  out_item_t exp_q[$];
  plan_t     plan_q[$];
  in_item_t  stim_q[$];

  int errors = 0;
  int quiet = 0;
  int n_items = 0;
  int n_results = 0;
  int n_near = 0;
  int n_short = 0;
  int n_far = 0;
  int n_block_ends = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold = 0;

  lz_window_decompressor #(.WINDOW_SIZE(WINDOW)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #10 clk = ~clk;

  function automatic void put_byte(input logic [7:0] b);
    hist[wpos] = b;
    wpos = wpos + DIST_W'(1);
    fresh_q.push_back('{out_byte: b, last_of_run: 1'b0});
  endfunction

  function automatic void copy_back(input logic [DIST_W-1:0] distance,
                                    input logic [LEN_W-1:0] len);
    logic [DIST_W-1:0] src;
    for (int i = 0; i < int'(len); i++) begin
      src = wpos - distance;
      put_byte(hist[src]);
    end
  endfunction

  function automatic void end_match(input logic [3:0] trail);
    lits_left = LIT_W'(trail);
    phase = (trail != 4'd0) ? PH_LITERAL : PH_TOKEN;
  endfunction

  function automatic void decode_byte(input in_item_t it);
    logic [7:0]        b;
    logic [7:0]        tk;
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  len;
    b = it.in_byte;
    tk = tok_hold;
    fresh_q.delete();
    case (phase)
      PH_TOKEN: begin
        tok_hold = b;
        if (b[7:6] == KIND_LITERAL) begin
          lits_left = LIT_W'(b[5:0]) + LIT_W'(1);
          phase = PH_LITERAL;
        end else begin
          phase = PH_PARAM1;
        end
      end
      PH_PARAM1: begin
        if (tk[7:6] == KIND_NEAR) begin
          distance = DIST_W'({tk[5:0], b[7:5]}) + DIST_BIAS;
          len = LEN_W'(b[4:0]) + LEN_BIAS_SHORT;
          copy_back(distance, len);
          end_match(4'd0);
          n_near++;
        end else if (tk[7:6] == KIND_SHORT) begin
          distance = DIST_W'({tk[5:0], b[7]}) + DIST_BIAS;
          len = LEN_W'(b[6:4]) + LEN_BIAS_SHORT;
          copy_back(distance, len);
          end_match(b[3:0]);
          n_short++;
        end else begin
          par_hold = b;
          phase = PH_PARAM2;
        end
      end
      PH_PARAM2: begin
        distance = {tk[5:0], par_hold[7:1]};
        len = LEN_W'({par_hold[0], b[7:4]}) + LEN_BIAS_FAR;
        copy_back(distance, len);
        end_match(b[3:0]);
        n_far++;
      end
      default: begin
        put_byte(b);
        lits_left = lits_left - LIT_W'(1);
        if (lits_left == '0) phase = PH_TOKEN;
      end
    endcase
    if (it.block_end) begin
      phase = PH_TOKEN;
      lits_left = '0;
      n_block_ends++;
    end
    if (fresh_q.size() > 0) fresh_q[fresh_q.size() - 1].last_of_run = 1'b1;
  endfunction

  // Builds one token with its parameters and literals; a few are noise or are
  // broken off early by a block end.
  task automatic gen_group();
    in_item_t   grp[$];
    int         pick;
    int         cnt;
    int         cut;
    logic [7:0] t;
    logic [7:0] p;
    logic [7:0] q;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      grp.push_back('{in_byte: 8'($urandom), block_end: 1'b0});
    end else if (pick < 35) begin
      cnt = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
      grp.push_back('{in_byte: {KIND_LITERAL, 6'(cnt - 1)}, block_end: 1'b0});
      for (int i = 0; i < cnt; i++) grp.push_back('{in_byte: 8'($urandom), block_end: 1'b0});
    end else if (pick < 55) begin
      grp.push_back('{in_byte: {KIND_NEAR, 6'($urandom)}, block_end: 1'b0});
      grp.push_back('{in_byte: 8'($urandom), block_end: 1'b0});
    end else begin
      cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
      p = 8'($urandom);
      if (pick < 75) begin
        p[3:0] = 4'(cnt);
        grp.push_back('{in_byte: {KIND_SHORT, 6'($urandom)}, block_end: 1'b0});
        grp.push_back('{in_byte: p, block_end: 1'b0});
      end else begin
        t = {KIND_FAR, 6'($urandom)};
        q = 8'($urandom);
        q[3:0] = 4'(cnt);
        if ($urandom_range(0, 19) == 0) begin
          t[5:0] = 6'd0;
          p[7:1] = 7'd0;
        end
        grp.push_back('{in_byte: t, block_end: 1'b0});
        grp.push_back('{in_byte: p, block_end: 1'b0});
        grp.push_back('{in_byte: q, block_end: 1'b0});
      end
      for (int i = 0; i < cnt; i++) grp.push_back('{in_byte: 8'($urandom), block_end: 1'b0});
    end
    pick = $urandom_range(0, 99);
    if (pick < 4 && grp.size() > 1) begin
      cut = $urandom_range(0, grp.size() - 2);
      while (grp.size() > cut + 1) void'(grp.pop_back());
      grp[cut].block_end = 1'b1;
    end else if (pick < 10) begin
      grp[grp.size() - 1].block_end = 1'b1;
    end
    foreach (grp[i]) stim_q.push_back(grp[i]);
  endtask

  task automatic drive_item(input in_item_t it, input plan_t pl);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    plan_q.push_back(pl);
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
  endtask

  // Sampled at the falling edge so that the monitor has finished with the queue.
  task automatic wait_drained();
    do @(negedge clk); while (exp_q.size() != 0);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      result_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_idle_pct) begin
      rx_hold <= $urandom_range(0, 17);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Input transactions are predicted before output transactions are checked,
  // all in one process, so that a same-edge result cannot race its prediction.
  always @(posedge clk) begin : monitor
    plan_t     pl;
    out_item_t want;
    if ((item_valid && item_ready) || (result_valid && result_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (!rst) begin
      if (item_valid && item_ready) begin
        pl = plan_q.pop_front();
        decode_byte(item);
        n_items++;
        if (pl.typed) begin
          for (int k = 0; k < pl.n; k++)
            exp_q.push_back('{out_byte: pl.val, last_of_run: (k == pl.n - 1)});
        end else begin
          foreach (fresh_q[k]) exp_q.push_back(fresh_q[k]);
        end
      end
      if (result_valid && result_ready) begin
        n_results++;
        if (exp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected output byte %h last %b", $time,
                   result.out_byte, result.last_of_run);
        end else begin
          want = exp_q.pop_front();
          if (result.out_byte !== want.out_byte) begin
            errors++;
            $display("%0t: out_byte expected %h actual %h", $time,
                     want.out_byte, result.out_byte);
          end
          if (result.last_of_run !== want.last_of_run) begin
            errors++;
            $display("%0t: last_of_run expected %b actual %b", $time,
                     want.last_of_run, result.last_of_run);
          end
        end
      end
    end
  end

  initial begin : watchdog
    do @(negedge clk); while (quiet < WATCHDOG_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int    total;
    plan_t pl;
    for (int i = 0; i < WINDOW; i++) hist[i] = 8'h00;
    wpos = '0;
    phase = PH_TOKEN;
    tok_hold = 8'h00;
    par_hold = 8'h00;
    lits_left = '0;
    tx_idle_pct = 15;
    rx_idle_pct = 15;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      pl = '{typed: DIRECTED[r].typed, n: int'(DIRECTED[r].n), val: DIRECTED[r].val};
      drive_item('{in_byte: DIRECTED[r].b, block_end: DIRECTED[r].be}, pl);
    end
    item_valid <= 1'b0;
    wait_drained();

    while (stim_q.size() < RANDOM_ITEMS) gen_group();
    total = stim_q.size();
    for (int idx = 0; idx < total; idx++) begin
      if (idx >= total - CALM_TAIL) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (idx % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       tx_idle_pct = 0;
          1:       tx_idle_pct = 15;
          default: tx_idle_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0:       rx_idle_pct = 0;
          1:       rx_idle_pct = 15;
          default: rx_idle_pct = 40;
        endcase
      end
      // Let the output side run completely dry once in mid-stream.
      if (idx == total / 2) begin
        item_valid <= 1'b0;
        wait_drained();
      end
      drive_item(stim_q[idx], '{typed: 1'b0, n: 0, val: 8'h00});
    end
    item_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Decoded %0d input and %0d output transactions, %0d block ends.",
             n_items, n_results, n_block_ends);
    $display("Matches: %0d near, %0d short, %0d far; %0d mismatches.",
             n_near, n_short, n_far, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
